// ----- rtl/raw_byte_stream_pixel_unpacker_macros.svh -----
// Assertion helpers for the unpacker RTL, used by rbspu_outq.
`ifndef RAW_BYTE_STREAM_PIXEL_UNPACKER_MACROS_SVH
`define RAW_BYTE_STREAM_PIXEL_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
`define RBSPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbspu: same-cycle check failed");
`define RBSPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbspu: next-cycle check failed");
`else
`define RBSPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RBSPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/rbspu_pkg.sv -----
`timescale 1ns / 1ps
package rbspu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int DIM_FLD_W  = 14;
  localparam int NUM_SLOTS  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_IS_RAW10  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd4;

  localparam logic [4:0]           BPP_RST          = 5'd10;
  localparam logic [4:0]           BPP_RAW10        = 5'd10;
  localparam logic [4:0]           BPP_MAX_ONE_BYTE = 5'd8;
  localparam logic [DIM_FLD_W-1:0] WIDTH_RST        = 14'd1920;
  localparam logic [DIM_FLD_W-1:0] HEIGHT_RST       = 14'd1080;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } rbspu_in_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        last_of_run;
    logic        end_of_frame;
    logic [1:0]  status;
  } rbspu_out_t;

  typedef struct packed {
    logic [2:0]                    count;
    rbspu_out_t [NUM_SLOTS-1:0]    slot;
  } rbspu_bundle_t;

endpackage

// ----- rtl/rbspu_core.sv -----
`timescale 1ns / 1ps
module rbspu_core #(
  parameter int MAX_DIMENSION = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  rbspu_pkg::rbspu_in_t                in_data,
  input  logic                                cfg_we,
  input  logic [rbspu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbspu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output rbspu_pkg::rbspu_bundle_t            bundle
);
  import rbspu_pkg::*;

  localparam int DIM_MAX = (MAX_DIMENSION < 16383) ? MAX_DIMENSION : 16383;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int TOT_W   = $clog2(DIM_MAX * DIM_MAX + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_FLD_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v > DIM_FLD_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  localparam logic [2*DIM_W-1:0] TOTAL_RST_FULL = clamp_dim(WIDTH_RST) * clamp_dim(HEIGHT_RST);

  logic                 packed_mode_r, packed_mode_nxt;
  logic [4:0]           bpp_r, bpp_nxt;
  logic                 raw10_r, raw10_nxt;
  logic [DIM_FLD_W-1:0] width_r, width_nxt;
  logic [DIM_FLD_W-1:0] height_r, height_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;

  logic [31:0]          hold_r, hold_nxt;
  logic [2:0]           phase_r, phase_nxt;
  logic [TOT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [2*DIM_W-1:0]   prod;
  logic [DIM_W-1:0]     mul_a, mul_b;
  logic                 accept;
  logic [TOT_W-1:0]     target;
  logic [TOT_W-1:0]     remain;
  logic                 stop;
  logic [2:0]           ngrp;
  logic                 unsup;
  logic [7:0]           b;
  rbspu_bundle_t        bnd;

  assign accept = in_valid && !in_stall;
  assign b      = in_data.data_byte;
  assign target = packed_mode_r ? {total_r[TOT_W-1:2], 2'b00} : total_r;
  assign unsup  = packed_mode_r && !raw10_r && (bpp_r != BPP_RAW10);

  // total pixel count tracks the dimension registers at write time
  always_comb begin
    mul_a = clamp_dim(width_r);
    mul_b = clamp_dim(height_r);
    if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
      mul_a = clamp_dim(cfg_wdata);
    end
    if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
      mul_b = clamp_dim(cfg_wdata);
    end
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    packed_mode_nxt = packed_mode_r;
    bpp_nxt         = bpp_r;
    raw10_nxt       = raw10_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    total_nxt       = total_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PACKED_MODE:    packed_mode_nxt = cfg_wdata[0];
        CFG_BITS_PER_PIXEL: bpp_nxt = cfg_wdata[4:0];
        CFG_TYPE_IS_RAW10:  raw10_nxt = cfg_wdata[0];
        CFG_FRAME_WIDTH: begin
          width_nxt = cfg_wdata;
          total_nxt = prod[TOT_W-1:0];
        end
        CFG_FRAME_HEIGHT: begin
          height_nxt = cfg_wdata;
          total_nxt  = prod[TOT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    bnd       = '0;
    remain    = target - cnt_r;
    stop      = 1'b0;
    ngrp      = 3'd0;
    if (accept) begin
      if (in_data.frame_start) begin
        hold_nxt  = '0;
        phase_nxt = '0;
        cnt_nxt   = '0;
        done_nxt  = 1'b0;
      end
      remain = target - cnt_nxt;
      if (in_data.frame_start && unsup) begin
        bnd.count                   = 3'd1;
        bnd.slot[0].end_of_frame    = 1'b1;
        bnd.slot[0].status          = ST_UNSUP;
        done_nxt                    = 1'b1;
      end else if (in_data.frame_start && total_r == '0) begin
        done_nxt = 1'b1;
      end else if (in_data.frame_start && packed_mode_r && total_r < TOT_W'(4)) begin
        bnd.count                   = 3'd1;
        bnd.slot[0].end_of_frame    = 1'b1;
        bnd.slot[0].status          = ST_TAIL;
        done_nxt                    = 1'b1;
      end else if (!done_nxt) begin
        if (cnt_nxt >= target) begin
          done_nxt = 1'b1;
        end else if (packed_mode_r) begin
          if (phase_nxt < 3'd4) begin
            hold_nxt  = hold_nxt | (32'(b) << {phase_nxt[1:0], 3'b000});
            phase_nxt = phase_nxt + 3'd1;
          end else begin
            stop = remain <= TOT_W'(4);
            ngrp = stop ? remain[2:0] : 3'd4;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              bnd.slot[i].pixel_value = {6'b0, b[2*i+1 -: 2], hold_nxt[8*i+7 -: 8]};
              if (stop && (3'(i) + 3'd1 == ngrp)) begin
                bnd.slot[i].end_of_frame = 1'b1;
                if (total_r[1:0] != 2'b00) begin
                  bnd.slot[i].status      = ST_TAIL;
                  bnd.slot[i].pixel_value = '0;
                end
              end
            end
            bnd.count = ngrp;
            cnt_nxt   = cnt_nxt + TOT_W'(ngrp);
            done_nxt  = stop;
            hold_nxt  = '0;
            phase_nxt = '0;
          end
        end else if (bpp_r >= 5'd1 && bpp_r <= BPP_MAX_ONE_BYTE) begin
          bnd.count                = 3'd1;
          bnd.slot[0].pixel_value  = {8'b0, b};
          bnd.slot[0].end_of_frame = remain == TOT_W'(1);
          done_nxt                 = remain == TOT_W'(1);
          cnt_nxt                  = cnt_nxt + TOT_W'(1);
        end else begin
          if (phase_nxt == 3'd0) begin
            hold_nxt  = {24'b0, b};
            phase_nxt = 3'd1;
          end else begin
            bnd.count                = 3'd1;
            bnd.slot[0].pixel_value  = {b, hold_nxt[7:0]};
            bnd.slot[0].end_of_frame = remain == TOT_W'(1);
            done_nxt                 = remain == TOT_W'(1);
            cnt_nxt                  = cnt_nxt + TOT_W'(1);
            hold_nxt                 = '0;
            phase_nxt                = '0;
          end
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bnd.slot[i].last_of_run = (bnd.count != 3'd0) && (3'(i) + 3'd1 == bnd.count);
      end
    end
  end

  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_mode_r <= 1'b0;
      bpp_r         <= BPP_RST;
      raw10_r       <= 1'b1;
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
      total_r       <= TOTAL_RST_FULL[TOT_W-1:0];
      hold_r        <= '0;
      phase_r       <= '0;
      cnt_r         <= '0;
      done_r        <= 1'b1;
    end else begin
      packed_mode_r <= packed_mode_nxt;
      bpp_r         <= bpp_nxt;
      raw10_r       <= raw10_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      total_r       <= total_nxt;
      hold_r        <= hold_nxt;
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      done_r        <= done_nxt;
    end
  end

endmodule

// ----- rtl/rbspu_outq.sv -----
`timescale 1ns / 1ps
`include "raw_byte_stream_pixel_unpacker_macros.svh"
module rbspu_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbspu_pkg::rbspu_bundle_t   bundle,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rbspu_pkg::rbspu_out_t      out_data
);
  import rbspu_pkg::*;

  logic                         valid_r, valid_nxt;
  logic [1:0]                   idx_r, idx_nxt;
  logic [1:0]                   last_r, last_nxt;
  rbspu_out_t [NUM_SLOTS-1:0]   slot_r, slot_nxt;
  logic                         out_fire;
  logic                         drain_done;
  logic                         load;

  assign out_fire   = valid_r && !out_stall;
  assign drain_done = out_fire && (idx_r == last_r);
  assign in_stall   = valid_r && !drain_done;
  assign load       = bundle.count != 3'd0;
  assign out_valid  = valid_r;
  assign out_data   = slot_r[idx_r];

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    slot_nxt  = slot_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
      last_nxt  = 2'(bundle.count - 3'd1);
      slot_nxt  = bundle.slot;
    end else if (drain_done) begin
      valid_nxt = 1'b0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      last_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
    slot_r <= slot_nxt;
  end

  `RBSPU_ASSERT_IMP(a_no_load_while_busy, clk, rst_n, in_stall, !load)
  `RBSPU_ASSERT_IMP(a_idx_in_run, clk, rst_n, valid_r, idx_r <= last_r)
  `RBSPU_ASSERT_NXT(a_run_continues, clk, rst_n, out_fire && (idx_r != last_r), out_valid)
  `RBSPU_ASSERT_IMP(a_eof_ends_run, clk, rst_n, out_valid && out_data.end_of_frame, out_data.last_of_run)
  `RBSPU_ASSERT_IMP(a_bad_status_zero, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.pixel_value == '0)

endmodule

// ----- rtl/raw_byte_stream_pixel_unpacker.sv -----
`timescale 1ns / 1ps
// The first pixel released by a byte is offered in the cycle after the byte is taken.
// Bytes: one per cycle while in_stall is low; a byte that releases pixels holds the
// input until the output register has drained them, one pixel per cycle unless out_stall.
// Packed RAW10: five bytes per four pixels; the fifth byte releases all four.
// Reset (rst_n low, synchronous): registers to defaults, no frame open until frame_start.
module raw_byte_stream_pixel_unpacker #(
  parameter int MAX_DIMENSION = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbspu_pkg::rbspu_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rbspu_pkg::rbspu_out_t               out_data,
  input  logic                                cfg_we,
  input  logic [rbspu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbspu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rbspu_pkg::*;

  rbspu_bundle_t bundle;

  rbspu_core #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .bundle   (bundle)
  );

  rbspu_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .bundle   (bundle),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
